### hdl/frt_pkg.sv
package frt_pkg;

  localparam int FRAME_SLOTS = 8;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_VERSION  = 4'd2;
  localparam logic [3:0] ST_LENGTH   = 4'd3;
  localparam logic [3:0] ST_TYPE     = 4'd4;
  localparam logic [3:0] ST_MISMATCH = 4'd5;
  localparam logic [3:0] ST_INDEX    = 4'd6;
  localparam logic [3:0] ST_DUP      = 4'd7;
  localparam logic [3:0] ST_OVERFLOW = 4'd8;
  localparam logic [3:0] ST_BUSY     = 4'd9;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_DONE     = 2'd1;
  localparam logic [1:0] EV_LOST     = 2'd2;

  localparam logic [1:0] LOSS_NONE   = 2'd0;
  localparam logic [1:0] LOSS_MISS   = 2'd1;
  localparam logic [1:0] LOSS_TIME   = 2'd2;

  localparam logic [7:0] FRAGMENT_TYPE = 8'd0;

  localparam logic [0:0] REG_VERSION = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [15:0] packet_size;
    logic [15:0] version;
    logic [7:0]  packet_type;
    logic [31:0] frame_index;
    logic [31:0] time_stamp;
    logic [23:0] total_size;
    logic [6:0]  fragment_count;
    logic [5:0]  fragment_number;
    logic [23:0] byte_offset;
    logic [15:0] fragment_size;
  } frag_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  event_kind;
    logic [1:0]  loss_kind;
    logic [31:0] event_frame;
    logic [2:0]  event_slot;
    logic [23:0] write_offset;
  } result_t;

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] stamp;
    logic [23:0] total;
    logic [6:0]  count;
    logic [31:0] bytes_seen;
    logic [63:0] seen_map;
  } slot_t;

endpackage

### hdl/frt_if.sv
interface frag_if;
  import frt_pkg::*;
  logic  valid;
  logic  ready;
  frag_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface result_if;
  import frt_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/frt_ram.sv
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### hdl/fragment_reassembly_tracker.sv
// Fragment reassembly tracker.
// frag_in carries one fragment header per item; res_out returns exactly one
// result item per fragment, in order: a status, an event on the oldest
// outstanding frame (completion or loss) and the payload write offset.
// The slot table sits in one synchronous RAM with a single read port, so a
// fragment takes a read of its own slot, a write-back, then a read of the
// oldest slot, through states RD, MOD, ORD and OLD before OUT, with one
// fragment in flight at a time. A header reject skips the slot stage and
// goes from RD straight to OUT. The next fragment is taken only after the
// result has left and the tracker is back in IDLE.
// Configuration: cfg_we_i writes expected_version (index 0) or timeout_ms
// (index 1) from cfg_data_i; write only while idle.
// Reset clears the slot-used flags, the latest and oldest trackers and the
// registers to version 1 and timeout 100; the RAM needs no clearing.
// When res_out stalls the result holds in its register and no further
// fragment is accepted until it leaves.
module fragment_reassembly_tracker #(
  parameter int MaxFragments = 64,
  parameter int HeaderBytes  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  frag_if.sink        frag_in,
  result_if.source    res_out
);
  import frt_pkg::*;

  localparam int SW = $clog2(FRAME_SLOTS);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_MOD = 3'd2,
                         S_ORD = 3'd3, S_OLD = 3'd4, S_OUT = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [15:0] ver_q, tmo_q;
  frag_t       f_q;
  result_t     r_q, r_d;
  logic [FRAME_SLOTS-1:0] used_q, used_d;
  logic        lk_q, lk_d, ok_q, ok_d;
  logic [31:0] lf_q, lf_d, lt_q, lt_d, of_q, of_d;

  logic        we;
  logic [SW-1:0] waddr, raddr;
  slot_t       wdata, rdata;

  frt_ram #(.Width($bits(slot_t)), .Depth(FRAME_SLOTS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [SW-1:0] s_idx, o_idx;
  assign s_idx = f_q.frame_index[SW-1:0];
  assign o_idx = of_q[SW-1:0];

  assign frag_in.ready = (state_q == S_IDLE);
  assign res_out.valid = (state_q == S_OUT);
  assign res_out.data  = r_q;

  slot_t       sl;
  logic [63:0] need, bit_m;
  logic [24:0] end_b;
  logic [3:0]  hstat;

  always_comb begin
    if (f_q.packet_size < 16'(HeaderBytes)) hstat = ST_SHORT;
    else if (f_q.version != ver_q) hstat = ST_VERSION;
    else if (17'(f_q.fragment_size) + 17'(HeaderBytes) != 17'(f_q.packet_size))
      hstat = ST_LENGTH;
    else if (f_q.packet_type != FRAGMENT_TYPE) hstat = ST_TYPE;
    else hstat = ST_OK;
  end

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    used_d = used_q;
    lk_d = lk_q; lf_d = lf_q; lt_d = lt_q; ok_d = ok_q; of_d = of_q;
    we = 1'b0;
    waddr = s_idx;
    wdata = rdata;
    raddr = s_idx;
    sl = rdata;
    need = '0;
    bit_m = 64'd1 << f_q.fragment_number;
    end_b = 25'(f_q.byte_offset) + 25'(f_q.fragment_size);
    unique case (state_q)
      S_IDLE: if (frag_in.valid) state_d = S_RD;
      S_RD: begin
        r_d = '0;
        r_d.status = hstat;
        if (hstat != ST_OK) state_d = S_OUT;
        else begin
          if (!lk_q || f_q.frame_index > lf_q) begin
            lk_d = 1'b1; lf_d = f_q.frame_index; lt_d = f_q.time_stamp;
          end
          if (!ok_q) begin
            ok_d = 1'b1; of_d = f_q.frame_index;
          end
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (used_q[s_idx] && rdata.frame != f_q.frame_index) begin
          r_d.status = ST_BUSY;
        end else begin
          if (!used_q[s_idx]) begin
            sl.frame = f_q.frame_index; sl.stamp = f_q.time_stamp;
            sl.total = f_q.total_size; sl.count = f_q.fragment_count;
            sl.bytes_seen = '0; sl.seen_map = '0;
            used_d[s_idx] = 1'b1;
          end
          if (f_q.fragment_count != sl.count || f_q.time_stamp != sl.stamp ||
              f_q.total_size != sl.total)
            r_d.status = ST_MISMATCH;
          else if (7'(f_q.fragment_number) >= sl.count ||
                   7'(f_q.fragment_number) >= 7'(MaxFragments))
            r_d.status = ST_INDEX;
          else if ((sl.seen_map & bit_m) != '0) r_d.status = ST_DUP;
          else if (end_b > 25'(sl.total)) r_d.status = ST_OVERFLOW;
          else begin
            sl.seen_map = sl.seen_map | bit_m;
            sl.bytes_seen = sl.bytes_seen + 32'(f_q.fragment_size);
            r_d.write_offset = f_q.byte_offset;
          end
          we = 1'b1;
          wdata = sl;
        end
        state_d = S_ORD;
      end
      S_ORD: begin
        raddr = o_idx;
        state_d = S_OLD;
      end
      S_OLD: begin
        raddr = o_idx;
        if (rdata.count == 7'd0 || rdata.count > 7'(MaxFragments)) need = '0;
        else if (rdata.count >= 7'd64) need = '1;
        else need = (64'd1 << rdata.count) - 64'd1;
        if (used_q != '0) begin
          if (!used_q[o_idx] || rdata.frame != of_q) begin
            r_d.event_kind = EV_LOST; r_d.loss_kind = LOSS_MISS;
            r_d.event_frame = of_q;
            if (lf_q > of_q) of_d = of_q + 32'd1;
          end else if (need != '0 && (rdata.seen_map & need) == need &&
                       rdata.bytes_seen == 32'(rdata.total)) begin
            r_d.event_kind = EV_DONE; r_d.event_frame = of_q;
            r_d.event_slot = 3'(o_idx);
            used_d[o_idx] = 1'b0;
            of_d = of_q + 32'd1;
          end else if ((lt_q - rdata.stamp) > 32'(tmo_q)) begin
            r_d.event_kind = EV_LOST; r_d.loss_kind = LOSS_TIME;
            r_d.event_frame = of_q;
            used_d[o_idx] = 1'b0;
            if (lf_q > of_q) of_d = of_q + 32'd1;
          end
        end
        state_d = S_OUT;
      end
      S_OUT: if (res_out.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ver_q <= 16'd1; tmo_q <= 16'd100;
      used_q <= '0;
      lk_q <= 1'b0; lf_q <= '0; lt_q <= '0; ok_q <= 1'b0; of_q <= '0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      lk_q <= lk_d; lf_q <= lf_d; lt_q <= lt_d; ok_q <= ok_d; of_q <= of_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_VERSION) ver_q <= cfg_data_i;
        else tmo_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frag_in.valid && frag_in.ready) f_q <= frag_in.data;
    r_q <= r_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.ready) |=> res_out.valid && $stable(r_q))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |=> !we)
    else $error("second write in one fragment");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frag_in.valid && frag_in.ready) |=> !res_out.valid)
    else $error("result before processing");
endmodule
